// ===== src/rbsm_pkg.sv =====
package rbsm_pkg;

   // default geometry of the modulator
   localparam int SPS_DEFAULT        = 16;
   localparam int FILTER_LEN_DEFAULT = 128;
   localparam int RING_LEN_DEFAULT   = 144;

   // fixed field widths
   localparam int COEF_W  = 16;
   localparam int ACC_W   = 20;
   localparam int INDEX_W = 7;

   // item kinds carried on req_tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_COEF = 1'b1;

   // ring access strobes from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

endpackage

// ===== src/rbsm_wave_store.sv =====
module rbsm_wave_store #(
   parameter int FILTER_LEN = rbsm_pkg::FILTER_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [rbsm_pkg::INDEX_W-1:0]       wr_index,
   input  logic signed [rbsm_pkg::COEF_W-1:0] wr_value,
   input  logic                               rd_en,
   input  logic [$clog2(FILTER_LEN)-1:0]      rd_addr,
   output logic signed [rbsm_pkg::COEF_W-1:0] rd_data
);

   localparam int FAW = $clog2(FILTER_LEN);

   logic signed [rbsm_pkg::COEF_W-1:0] mem [FILTER_LEN];
   logic signed [rbsm_pkg::COEF_W-1:0] rd_data_ff;
   logic                               in_range;

   // writes beyond the table are dropped
   assign in_range = (32'(wr_index) < 32'(FILTER_LEN));

   // waveform memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[FAW'(wr_index)] <= wr_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rbsm_accum_ring.sv =====
module rbsm_accum_ring #(
   parameter int RING_LEN = rbsm_pkg::RING_LEN_DEFAULT
) (
   input  logic                              clock,
   input  rbsm_pkg::ring_ctl_type            ctl,
   input  logic [$clog2(RING_LEN)-1:0]       rd_addr,
   input  logic [$clog2(RING_LEN)-1:0]       wr_addr,
   input  logic signed [rbsm_pkg::ACC_W-1:0] wr_data,
   output logic signed [rbsm_pkg::ACC_W-1:0] rd_data
);

   logic signed [rbsm_pkg::ACC_W-1:0] mem [RING_LEN];
   logic signed [rbsm_pkg::ACC_W-1:0] rd_data_ff;

   // accumulation ring, read data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rbsm_seq.sv =====
module rbsm_seq #(
   parameter int SAMPLES_PER_SYMBOL = rbsm_pkg::SPS_DEFAULT,
   parameter int FILTER_LEN         = rbsm_pkg::FILTER_LEN_DEFAULT,
   parameter int RING_LEN           = rbsm_pkg::RING_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              tick_start,
   input  logic                              data_bit,
   input  logic                              out_free,
   input  logic signed [rbsm_pkg::ACC_W-1:0] ring_rd_data,
   input  logic signed [rbsm_pkg::COEF_W-1:0] wave_rd_data,
   output logic                              idle,
   output rbsm_pkg::ring_ctl_type            ring_ctl,
   output logic [$clog2(RING_LEN)-1:0]       ring_rd_addr,
   output logic [$clog2(RING_LEN)-1:0]       ring_wr_addr,
   output logic signed [rbsm_pkg::ACC_W-1:0] ring_wr_data,
   output logic                              wave_rd_en,
   output logic [$clog2(FILTER_LEN)-1:0]     wave_rd_addr,
   output logic                              out_load,
   output logic signed [rbsm_pkg::ACC_W-1:0] out_sample,
   output logic                              out_taken
);

   localparam int RAW     = $clog2(RING_LEN);
   localparam int FAW     = $clog2(FILTER_LEN);
   localparam int JW      = $clog2(FILTER_LEN + 1);
   localparam int TW      = $clog2(SAMPLES_PER_SYMBOL + 1);
   localparam int SPS_MOD = SAMPLES_PER_SYMBOL % RING_LEN;
   localparam logic [RAW-1:0] RING_LAST = RAW'(RING_LEN - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ADD   = 5'b00100,
      ST_SREAD = 5'b01000,
      ST_SOUT  = 5'b10000
   } seq_state_type;

   seq_state_type  state_ff, state_in;
   logic [RAW-1:0] idx_ff, idx_in;
   logic [RAW-1:0] wp_ff, wp_in;
   logic [RAW-1:0] rp_ff, rp_in;
   logic [JW-1:0]  j_ff, j_in;
   logic           p_ff, p_in;
   logic [RAW-1:0] p_addr_ff, p_addr_in;
   logic [TW-1:0]  tick_ff, tick_in;
   logic           diff_ff, diff_in;
   logic           taken_ff, taken_in;

   logic                              issue;
   logic [RAW:0]                      wp_sum;
   logic [RAW-1:0]                    wp_next;
   logic [RAW-1:0]                    idx_step;
   logic [RAW-1:0]                    rp_step;
   logic signed [rbsm_pkg::ACC_W-1:0] coef_ext;
   logic signed [rbsm_pkg::ACC_W-1:0] addend;

   // ring position arithmetic
   assign idx_step = (idx_ff == RING_LAST) ? '0 : idx_ff + RAW'(1);
   assign rp_step  = (rp_ff == RING_LAST) ? '0 : rp_ff + RAW'(1);
   assign wp_sum   = {1'b0, wp_ff} + (RAW + 1)'(SPS_MOD);
   assign wp_next  = (wp_sum >= (RAW + 1)'(RING_LEN)) ?
                     RAW'(wp_sum - (RAW + 1)'(RING_LEN)) : RAW'(wp_sum);

   // shaped coefficient, negated for output bit zero
   assign issue    = (j_ff != JW'(FILTER_LEN));
   assign coef_ext = rbsm_pkg::ACC_W'(wave_rd_data);
   assign addend   = diff_ff ? coef_ext : -coef_ext;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      j_in         = j_ff;
      p_in         = 1'b0;
      p_addr_in    = p_addr_ff;
      tick_in      = tick_ff;
      diff_in      = diff_ff;
      taken_in     = taken_ff;
      ring_ctl     = '0;
      ring_rd_addr = idx_ff;
      ring_wr_addr = p_addr_ff;
      ring_wr_data = ring_rd_data + addend;
      wave_rd_en   = 1'b0;
      wave_rd_addr = j_ff[FAW-1:0];
      out_load     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ring_ctl.wr_en = 1'b1;
            ring_wr_addr   = idx_ff;
            ring_wr_data   = '0;
            if (idx_ff == RING_LAST) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_step;
            end
         end
         ST_IDLE: begin
            if (tick_start) begin
               if (tick_ff >= TW'(SAMPLES_PER_SYMBOL)) begin
                  diff_in  = diff_ff ^ data_bit;
                  taken_in = 1'b1;
                  tick_in  = TW'(1);
                  idx_in   = wp_ff;
                  j_in     = '0;
                  state_in = ST_ADD;
               end else begin
                  tick_in  = tick_ff + TW'(1);
                  taken_in = 1'b0;
                  state_in = ST_SREAD;
               end
            end
         end
         ST_ADD: begin
            // read stage for the next tap
            if (issue) begin
               ring_ctl.rd_en = 1'b1;
               wave_rd_en     = 1'b1;
               j_in           = j_ff + JW'(1);
               idx_in         = idx_step;
               p_in           = 1'b1;
               p_addr_in      = idx_ff;
            end
            // write back stage for the previous tap
            if (p_ff) begin
               ring_ctl.wr_en = 1'b1;
            end
            if (!issue && !p_ff) begin
               wp_in    = wp_next;
               state_in = ST_SREAD;
            end
         end
         ST_SREAD: begin
            ring_ctl.rd_en = 1'b1;
            ring_rd_addr   = rp_ff;
            state_in       = ST_SOUT;
         end
         ST_SOUT: begin
            if (out_free) begin
               out_load       = 1'b1;
               ring_ctl.wr_en = 1'b1;
               ring_wr_addr   = rp_ff;
               ring_wr_data   = '0;
               rp_in          = rp_step;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
         j_ff     <= '0;
         p_ff     <= 1'b0;
         tick_ff  <= TW'(SAMPLES_PER_SYMBOL);
         diff_ff  <= 1'b0;
         taken_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         j_ff     <= j_in;
         p_ff     <= p_in;
         tick_ff  <= tick_in;
         diff_ff  <= diff_in;
         taken_ff <= taken_in;
      end
   end

   // write back address of the tap in flight
   always_ff @(posedge clock) begin
      p_addr_ff <= p_addr_in;
   end

   assign idle       = (state_ff == ST_IDLE);
   assign out_sample = ring_rd_data;
   assign out_taken  = taken_ff;

endmodule

// ===== src/rds_biphase_symbol_modulator.sv =====
// Differential biphase symbol modulator for RDS baseband.
// Input stream req_*: each item is either a sample tick (req_tuser = 0) or
// a waveform coefficient write (req_tuser = 1). A tick returns one item on
// rsp_*: the next baseband sample and whether data_bit was consumed. A
// coefficient write returns no item on rsp_*.
// Every SAMPLES_PER_SYMBOL ticks a tick starts a symbol: the data bit is
// differentially encoded and the waveform is overlap-added into the ring
// memory, one tap a cycle through a read, add and write-back pipeline.
// A plain tick reads the ring slot of the sample (ST_SREAD), then loads it
// into the output register and clears the slot (ST_SOUT); a tick that starts
// a symbol runs the overlap-add (ST_ADD) before these states. The next item
// is taken once the result has been placed in the output register.
// Reset: a clearing pass zeroes every ring slot while req_tready is held
// low. The waveform table is not cleared and must be loaded before use.
// When the receiver stalls, one result waits in the output register while
// the next item is still accepted and worked on; its result is held back
// until the register is free.
module rds_biphase_symbol_modulator #(
   parameter int SAMPLES_PER_SYMBOL = rbsm_pkg::SPS_DEFAULT,
   parameter int FILTER_LEN         = rbsm_pkg::FILTER_LEN_DEFAULT,
   parameter int RING_LEN           = rbsm_pkg::RING_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // data_bit, coef_index[6:0], coef_value[15:0]
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // sample_out[19:0], zero fill
   output logic        rsp_tuser   // bit_taken
);

   localparam int RAW = $clog2(RING_LEN);
   localparam int FAW = $clog2(FILTER_LEN);

   logic                               req_accept;
   logic                               data_bit;
   logic [rbsm_pkg::INDEX_W-1:0]       coef_index;
   logic signed [rbsm_pkg::COEF_W-1:0] coef_value;

   logic                              idle;
   rbsm_pkg::ring_ctl_type            ring_ctl;
   logic [RAW-1:0]                    ring_rd_addr;
   logic [RAW-1:0]                    ring_wr_addr;
   logic signed [rbsm_pkg::ACC_W-1:0] ring_wr_data;
   logic signed [rbsm_pkg::ACC_W-1:0] ring_rd_data;
   logic                              wave_rd_en;
   logic [FAW-1:0]                    wave_rd_addr;
   logic signed [rbsm_pkg::COEF_W-1:0] wave_rd_data;
   logic                              out_free;
   logic                              out_load;
   logic signed [rbsm_pkg::ACC_W-1:0] out_sample;
   logic                              out_taken;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [rbsm_pkg::ACC_W-1:0] sample_ff;
   logic                              taken_ff;

   // input unpacking
   assign req_accept = req_tvalid && req_tready;
   assign data_bit   = req_tdata[0];
   assign coef_index = req_tdata[7:1];
   assign coef_value = req_tdata[23:8];
   assign req_tready = idle;

   rbsm_wave_store #(
      .FILTER_LEN (FILTER_LEN)
   ) u_wave (
      .clock    (clock),
      .wr_en    (req_accept && (req_tuser == rbsm_pkg::OP_COEF)),
      .wr_index (coef_index),
      .wr_value (coef_value),
      .rd_en    (wave_rd_en),
      .rd_addr  (wave_rd_addr),
      .rd_data  (wave_rd_data)
   );

   rbsm_accum_ring #(
      .RING_LEN (RING_LEN)
   ) u_ring (
      .clock   (clock),
      .ctl     (ring_ctl),
      .rd_addr (ring_rd_addr),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_data (ring_rd_data)
   );

   rbsm_seq #(
      .SAMPLES_PER_SYMBOL (SAMPLES_PER_SYMBOL),
      .FILTER_LEN         (FILTER_LEN),
      .RING_LEN           (RING_LEN)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .tick_start   (req_accept && (req_tuser == rbsm_pkg::OP_TICK)),
      .data_bit     (data_bit),
      .out_free     (out_free),
      .ring_rd_data (ring_rd_data),
      .wave_rd_data (wave_rd_data),
      .idle         (idle),
      .ring_ctl     (ring_ctl),
      .ring_rd_addr (ring_rd_addr),
      .ring_wr_addr (ring_wr_addr),
      .ring_wr_data (ring_wr_data),
      .wave_rd_en   (wave_rd_en),
      .wave_rd_addr (wave_rd_addr),
      .out_load     (out_load),
      .out_sample   (out_sample),
      .out_taken    (out_taken)
   );

   // output register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         sample_ff <= out_sample;
         taken_ff  <= out_taken;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, sample_ff};
   assign rsp_tuser  = taken_ff;

   // checks
   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an item not yet taken");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("input taken before the ring was cleared");

   a_ring_no_collision: assert property (@(posedge clock) disable iff (reset)
      (ring_ctl.rd_en && ring_ctl.wr_en) |-> (ring_rd_addr != ring_wr_addr))
      else $error("ring read and write hit the same slot");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (wave_rd_en || out_load) |-> !req_accept)
      else $error("item accepted while the sequencer was busy");

endmodule
